// ===== design/ibp_pkg.sv =====
// Shared types and codes for the interval breakpoint partition block.
// Depends on nothing; imported by ibp_scan and interval_breakpoint_partition.
`default_nettype none

package ibp_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_COVER  = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    localparam logic [31:0] TOP_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] range_start;
        logic [31:0] range_end;
    } req_t;

    typedef struct packed {
        logic [31:0] out_start;
        logic [31:0] out_end;
        logic        has_range;
        logic        last;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    typedef struct packed {
        logic start_hit;
        logic end_hit;
    } scan_hit_t;

endpackage

`default_nettype wire

// ===== design/ibp_scan.sv =====
// Table scan accumulator: counts entries below the range bounds and flags exact hits.
// Depends on ibp_pkg; fed one table entry per sample from the top level's memory.
`default_nettype none

module ibp_scan
    import ibp_pkg::*;
#(
    parameter int CW = 7
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scan_ctl_t       ctl,
    input  wire logic [31:0]     key_start,
    input  wire logic [31:0]     key_end,
    input  wire logic [31:0]     entry,
    output logic      [CW-1:0]   below_start,
    output logic      [CW-1:0]   below_end,
    output scan_hit_t            hit
);

    logic [CW-1:0] below_start_reg;
    logic [CW-1:0] below_start_next;
    logic [CW-1:0] below_end_reg;
    logic [CW-1:0] below_end_next;
    scan_hit_t     hit_reg;
    scan_hit_t     hit_next;

    always_comb
    begin
        below_start_next = below_start_reg;
        below_end_next   = below_end_reg;
        hit_next         = hit_reg;
        if (ctl.clear)
        begin
            below_start_next = '0;
            below_end_next   = '0;
            hit_next         = '0;
        end
        else if (ctl.sample)
        begin
            if (entry < key_start)
            begin
                below_start_next = below_start_reg + CW'(1);
            end
            if (entry < key_end)
            begin
                below_end_next = below_end_reg + CW'(1);
            end
            if (entry == key_start)
            begin
                hit_next.start_hit = 1'b1;
            end
            if (entry == key_end)
            begin
                hit_next.end_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_start_reg <= '0;
            below_end_reg   <= '0;
            hit_reg         <= '0;
        end
        else
        begin
            below_start_reg <= below_start_next;
            below_end_reg   <= below_end_next;
            hit_reg         <= hit_next;
        end
    end

    assign below_start = below_start_reg;
    assign below_end   = below_end_reg;
    assign hit         = hit_reg;

endmodule

`default_nettype wire

// ===== design/interval_breakpoint_partition.sv =====
// Top level of the interval breakpoint partition: sequencer, point memory, result register.
// Depends on ibp_pkg and ibp_scan.
//
//   channel | signals                        | transaction
//   --------+--------------------------------+-------------------------------------
//   req     | req_valid, req_ready, req      | one command: insert, cover or list
//   rsp     | rsp_valid, rsp_ready, rsp      | one result; a run ends with last = 1
//
// Flow: a command with an immediate answer passes through S_RESP only. Insert and cover first scan
// the point_count stored points through the memory read port (one per cycle); an insert
// then shifts the table up once per new point (one entry per cycle through the single
// write port). Cover and list then stream one range per cycle while the output register
// is free. Reset clears the count only; the point memory is not cleared and its entries
// beyond the count are stale and never read. req_ready is high only between commands;
// a result waiting in the output register stalls the emitter, not the next acceptance.
`default_nettype none

module interval_breakpoint_partition
    import ibp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_EMRD  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // point memory
    logic [31:0]   mem [TABLE_DEPTH];
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // control
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          do_e_reg, do_e_next;
    logic          first_reg, first_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    req_t          req_reg, req_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [CW-1:0] k_reg, k_next;
    logic [31:0]   v_reg, v_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [31:0]   prev_reg, prev_next;
    logic [1:0]    stat_reg, stat_next;
    rsp_t          rsp_reg;

    logic          rsp_load;
    rsp_t          rsp_load_data;
    logic          rsp_free;

    scan_ctl_t     scan_ctl;
    logic [CW-1:0] below_start;
    logic [CW-1:0] below_end;
    scan_hit_t     scan_hit;

    // evaluation terms
    logic          need_s;
    logic          need_e;
    logic [CW:0]   total;
    logic [CW-1:0] lo_adj;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] lim_cover;
    logic [CW-1:0] idx_inc;

    ibp_scan #(
        .CW (CW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .key_start   (req_reg.range_start),
        .key_end     (req_reg.range_end),
        .entry       (rd_data_reg),
        .below_start (below_start),
        .below_end   (below_end),
        .hit         (scan_hit)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign idx_inc   = idx_reg + CW'(1);

    always_comb
    begin
        need_s    = !scan_hit.start_hit;
        need_e    = (req_reg.range_end != TOP_VALUE) && !scan_hit.end_hit;
        total     = {1'b0, count_reg} + (CW+1)'(need_s) + (CW+1)'(need_e);
        lo_adj    = below_start;
        if ((below_start != '0) && !scan_hit.start_hit)
        begin
            lo_adj = below_start - CW'(1);
        end
        cnt_m1    = count_reg - CW'(1);
        lim_cover = (below_end < cnt_m1) ? below_end : cnt_m1;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        do_e_next     = do_e_reg;
        first_next    = first_reg;
        req_next      = req_reg;
        dst_next      = dst_reg;
        k_next        = k_reg;
        v_next        = v_reg;
        lim_next      = lim_reg;
        prev_next     = prev_reg;
        stat_next     = stat_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = dst_reg;
        wr_data       = rd_data_reg;
        rsp_load      = 1'b0;
        rsp_load_data = '0;
        scan_ctl      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    scan_ctl.clear = 1'b1;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    stat_next      = STAT_OK;
                    state_next     = S_RESP;
                    unique case (req.command)
                        CMD_INSERT, CMD_COVER:
                        begin
                            if (req.range_start > req.range_end)
                            begin
                                stat_next = STAT_BAD;
                            end
                            else if (req.range_start != req.range_end)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                lim_next   = count_reg - CW'(1);
                                state_next = S_EMRD;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                scan_ctl.sample = pend_reg;
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    // last sample lands this cycle; counts are final in S_EVAL
                    pend_next  = 1'b0;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                stat_next  = STAT_OK;
                state_next = S_RESP;
                if (req_reg.command == CMD_INSERT)
                begin
                    if (total > {1'b0, DEPTH_C})
                    begin
                        stat_next = STAT_FULL;
                    end
                    else if (need_s)
                    begin
                        k_next     = below_start;
                        v_next     = req_reg.range_start;
                        idx_next   = count_reg;
                        pend_next  = 1'b0;
                        do_e_next  = need_e;
                        state_next = S_SHIFT;
                    end
                    else if (need_e)
                    begin
                        k_next     = below_end;
                        v_next     = req_reg.range_end;
                        idx_next   = count_reg;
                        pend_next  = 1'b0;
                        do_e_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else if ((count_reg != '0) && (lo_adj < lim_cover))
                begin
                    idx_next   = lo_adj;
                    lim_next   = lim_cover;
                    state_next = S_EMRD;
                end
            end

            S_SHIFT:
            begin
                // read entry j-1, write it to j next cycle; writes trail reads upward
                if (idx_reg > k_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(idx_reg - CW'(1));
                    dst_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg - CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                end
                else if (idx_reg <= k_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = k_reg[AW-1:0];
                    wr_data    = v_reg;
                    count_next = count_reg + CW'(1);
                    if (do_e_reg)
                    begin
                        // end point lands one slot higher, past the new start
                        k_next    = below_end + CW'(1);
                        v_next    = req_reg.range_end;
                        idx_next  = count_reg + CW'(1);
                        do_e_next = 1'b0;
                    end
                    else
                    begin
                        stat_next  = STAT_OK;
                        state_next = S_RESP;
                    end
                end
            end

            S_EMRD:
            begin
                rd_en      = 1'b1;
                first_next = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (first_reg)
                begin
                    prev_next  = rd_data_reg;
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[AW-1:0];
                    idx_next   = idx_inc;
                    first_next = 1'b0;
                end
                else if (rsp_free)
                begin
                    rsp_load                = 1'b1;
                    rsp_load_data.out_start = prev_reg;
                    rsp_load_data.out_end   = rd_data_reg;
                    rsp_load_data.has_range = 1'b1;
                    rsp_load_data.last      = (idx_reg == lim_reg);
                    rsp_load_data.status    = STAT_OK;
                    prev_next               = rd_data_reg;
                    if (idx_reg == lim_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                        idx_next = idx_inc;
                    end
                end
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_load             = 1'b1;
                    rsp_load_data.last   = 1'b1;
                    rsp_load_data.status = stat_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            do_e_reg      <= 1'b0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            do_e_reg      <= do_e_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        dst_reg  <= dst_next;
        k_reg    <= k_next;
        v_reg    <= v_next;
        lim_reg  <= lim_next;
        prev_reg <= prev_next;
        stat_reg <= stat_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_load_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== dv/tb_interval_breakpoint_partition.sv =====
// Self-checking testbench for interval_breakpoint_partition: directed and random commands,
// random stalls on both channels, results checked against a breakpoint table kept here.
// Depends on ibp_pkg and the RTL of interval_breakpoint_partition.
`timescale 1ns / 1ps

class partition_scoreboard #(int DEPTH = 64);

    logic [31:0]   points[DEPTH];
    int unsigned   npoints;
    ibp_pkg::rsp_t expected_q[$];

    int unsigned   errors;
    int unsigned   results_seen;
    int unsigned   ranges_seen;
    int unsigned   full_refusals;
    int unsigned   bad_ranges;
    int unsigned   cmd_counts[4];

    function new();
        npoints = 0;
        errors = 0;
        results_seen = 0;
        ranges_seen = 0;
        full_refusals = 0;
        bad_ranges = 0;
        foreach (cmd_counts[k]) cmd_counts[k] = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // index of the first point not below v, npoints if none
    function int unsigned lower_index(logic [31:0] v);
        int unsigned i;
        i = 0;
        while (i < npoints && points[i] < v)
            i++;
        return i;
    endfunction

    function bit has_point(logic [31:0] v);
        int unsigned i;
        i = lower_index(v);
        return (i < npoints) && (points[i] == v);
    endfunction

    function void add_point(logic [31:0] v);
        int unsigned i;
        i = lower_index(v);
        if ((i < npoints && points[i] == v) || npoints >= DEPTH)
            return;
        for (int unsigned j = npoints; j > i; j--)
            points[j] = points[j - 1];
        points[i] = v;
        npoints++;
    endfunction

    function void push_result(logic [31:0] s, logic [31:0] e, logic has, logic fin,
                              logic [1:0] st);
        ibp_pkg::rsp_t r;
        r.out_start = s;
        r.out_end   = e;
        r.has_range = has;
        r.last      = fin;
        r.status    = st;
        expected_q.push_back(r);
    endfunction

    // queue ranges that start at table indexes lo..hi-1, closing the run with last
    function void push_ranges(int unsigned lo, int unsigned hi);
        int unsigned n;
        n = 0;
        for (int unsigned i = lo; i < hi; i++)
        begin
            if (i + 1 < npoints && points[i] != ibp_pkg::TOP_VALUE)
            begin
                push_result(points[i], points[i + 1], 1'b1, 1'b0, ibp_pkg::STAT_OK);
                n++;
            end
        end
        if (n == 0)
            push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_OK);
        else
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void note_request(ibp_pkg::req_t item);
        logic [31:0] s;
        logic [31:0] e;
        int unsigned need;
        int unsigned lo;
        int unsigned hi;
        s = item.range_start;
        e = item.range_end;
        cmd_counts[item.command]++;
        case (item.command)
            ibp_pkg::CMD_INSERT:
            begin
                if (s > e)
                begin
                    bad_ranges++;
                    push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_BAD);
                end
                else if (s == e)
                begin
                    push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_OK);
                end
                else
                begin
                    need = 0;
                    if (!has_point(s))
                        need++;
                    if (e != ibp_pkg::TOP_VALUE && !has_point(e))
                        need++;
                    if (npoints + need > DEPTH)
                    begin
                        full_refusals++;
                        push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_FULL);
                    end
                    else
                    begin
                        add_point(s);
                        if (e != ibp_pkg::TOP_VALUE)
                            add_point(e);
                        push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_OK);
                    end
                end
            end
            ibp_pkg::CMD_COVER:
            begin
                if (s > e)
                begin
                    bad_ranges++;
                    push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_BAD);
                end
                else if (s == e)
                begin
                    push_ranges(0, 0);
                end
                else
                begin
                    // step back to the point at or below the start
                    lo = lower_index(s);
                    if (lo > 0 && (lo >= npoints || points[lo] != s))
                        lo--;
                    hi = lower_index(e);
                    push_ranges(lo, hi);
                end
            end
            ibp_pkg::CMD_LIST:
            begin
                if (npoints == 0)
                    push_ranges(0, 0);
                else
                    push_ranges(0, npoints - 1);
            end
            default: push_result('0, '0, 1'b0, 1'b1, ibp_pkg::STAT_OK);
        endcase
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s = 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    task check_result(ibp_pkg::rsp_t got);
        ibp_pkg::rsp_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected: %p", results_seen, got));
            return;
        end
        want = expected_q.pop_front();
        if (want.has_range)
            ranges_seen++;
        compare_field("out_start", got.out_start, want.out_start);
        compare_field("out_end", got.out_end, want.out_end);
        compare_field("has_range", 32'(got.has_range), 32'(want.has_range));
        compare_field("last", 32'(got.last), 32'(want.last));
        compare_field("status", 32'(got.status), 32'(want.status));
    endtask

endclass

module tb_interval_breakpoint_partition;
    import ibp_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 390;
    localparam int PAUSE_AT = 200;
    // longest quiet stretch of a correct run is a full-table insert
    // plus a sender gap and a receiver stall; IDLE_LIMIT lies above it
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 50;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    bit    quiet;
    int    idle_cycles;

    partition_scoreboard #(TABLE_DEPTH) sb;

    interval_breakpoint_partition #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, 4);
    endfunction

    // mix existing points and their neighbors, small values, full-width values and extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                if (sb.npoints == 0)
                    v = $urandom_range(0, 300);
                else
                    v = sb.points[$urandom_range(0, sb.npoints - 1)]
                        + 32'($signed($urandom_range(0, 2)) - 1);
            end
            4, 5, 6: v = $urandom_range(0, 300);
            7, 8:    v = $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'd0;
                    1:       v = 32'd1;
                    2:       v = TOP_VALUE - 1;
                    default: v = TOP_VALUE;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic issue(logic [1:0] cmd, logic [31:0] s, logic [31:0] e);
        req_t item;
        int   gap;
        item.command     = cmd;
        item.range_start = s;
        item.range_end   = e;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one edge first so the monitor has queued the last accepted transaction
    task automatic wait_for_drain();
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic issue_random();
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] t;
        int          pick;
        pick = $urandom_range(0, 99);
        s = pick_value();
        case ($urandom_range(0, 2))
            0:       e = s + $urandom_range(0, 500);
            1:       e = pick_value();
            default: e = TOP_VALUE;
        endcase
        // order the bounds unless a bad range is wanted
        if (s > e && pick < 95)
        begin
            t = s;
            s = e;
            e = t;
        end
        if (pick < 35)
            issue(CMD_INSERT, s, e);
        else if (pick < 75)
            issue(CMD_COVER, s, e);
        else if (pick < 90)
            issue(CMD_LIST, s, e);
        else if (pick < 95)
            issue(CMD_RESERVED, s, e);
        else
        begin
            if (s == e)
                e = s - 1;
            if (s < e)
            begin
                t = s;
                s = e;
                e = t;
            end
            issue(pick[0] ? CMD_INSERT : CMD_COVER, s, e);
        end
    endtask

    // receiver: random stall before each transaction, none during quiet stretches
    initial
    begin
        int gap;
        rsp_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // monitor and watchdog: sample both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        quiet = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, bad and empty ranges
        issue(CMD_LIST, 32'd0, 32'd0);
        issue(CMD_COVER, 32'd0, 32'd100);
        issue(CMD_INSERT, 32'd10, 32'd5);
        issue(CMD_COVER, 32'd10, 32'd5);
        issue(CMD_INSERT, 32'd7, 32'd7);
        // end at the top value adds only the start
        issue(CMD_INSERT, 32'd0, 32'd100);
        issue(CMD_INSERT, 32'hFFFF_FFF0, TOP_VALUE);
        issue(CMD_INSERT, 32'd100, 32'd200);
        issue(CMD_INSERT, 32'd0, TOP_VALUE);
        issue(CMD_LIST, TOP_VALUE, TOP_VALUE);
        issue(CMD_COVER, TOP_VALUE, TOP_VALUE);
        // start above all points steps back to the last one, which has no successor
        issue(CMD_COVER, 32'hFFFF_FFF8, TOP_VALUE);
        issue(CMD_COVER, 32'd150, 32'd160);
        issue(CMD_COVER, 32'd100, 32'd101);
        issue(CMD_COVER, 32'd0, TOP_VALUE);
        issue(CMD_INSERT, 32'd1, TOP_VALUE - 1);
        issue(CMD_COVER, 32'd1, TOP_VALUE - 1);
        issue(CMD_RESERVED, TOP_VALUE, TOP_VALUE);
        issue(CMD_RESERVED, 32'd0, 32'd0);
        issue(CMD_LIST, 32'd0, 32'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            issue_random();
            if (i == PAUSE_AT)
            begin
                // hold the sender until every outstanding result is back
                req_valid <= 1'b0;
                wait_for_drain();
            end
        end
        req_valid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

        $display("Ran %0d inserts, %0d covers, %0d lists, %0d reserved commands; %0d results",
                 sb.cmd_counts[CMD_INSERT], sb.cmd_counts[CMD_COVER], sb.cmd_counts[CMD_LIST],
                 sb.cmd_counts[CMD_RESERVED], sb.results_seen);
        $display("%0d ranges reported, %0d full refusals, %0d bad ranges, %0d points held",
                 sb.ranges_seen, sb.full_refusals, sb.bad_ranges, sb.npoints);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
